// ===== rtl/htt_pkg.sv =====
// ---------------------------------------------------------------------------
// HTTP header tokenizer package
// Shared constants, result codes and the command item passed from the
// classifier to the emitter.
// ---------------------------------------------------------------------------
package htt_pkg;

   localparam int PendingDepth = 16;   // default depth of the held-whitespace line
   localparam int CmdDepth     = 4;    // entries of the command queue
   localparam int CmdPtrW      = $clog2(CmdDepth);
   localparam int CmdCntW      = $clog2(CmdDepth + 1);

   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;

   typedef enum logic [1:0] {
      KIND_CONTENT  = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_DISCARD  = 2'd2,
      KIND_END      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      FLD_METHOD  = 3'd0,
      FLD_URL     = 3'd1,
      FLD_VERSION = 3'd2,
      FLD_NAME    = 3'd3,
      FLD_VALUE   = 3'd4
   } field_type;

   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,   // no field action
      OP_PLAIN     = 3'd1,   // content byte, no stripping
      OP_STRIP     = 3'd2,   // content byte with trailing-space hold
      OP_COMPLETE  = 3'd3,   // one field complete
      OP_COMPLETE2 = 3'd4    // name complete, then empty value complete
   } op_type;

   typedef struct packed {
      op_type     op;
      field_type  field;
      logic [7:0] data;
      logic       ws;
      logic       discard;
      field_type  discard_field;
      logic       last;
   } cmd_type;

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
   endfunction

endpackage

// ===== rtl/htt_front.sv =====
// ---------------------------------------------------------------------------
// HTTP header tokenizer front end
// Accepts datagram bytes, tracks the parse phase and turns each byte into
// at most one command for the emitter.
// ---------------------------------------------------------------------------
module htt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // last_byte
   input  logic              q_full,
   output logic              push,
   output htt_pkg::cmd_type  push_cmd
);
   import htt_pkg::*;

   typedef enum logic [9:0] {
      PH_METHOD      = 10'b00_0000_0001,
      PH_METHOD_URL  = 10'b00_0000_0010,
      PH_URL         = 10'b00_0000_0100,
      PH_URL_VERSION = 10'b00_0000_1000,
      PH_VERSION     = 10'b00_0001_0000,
      PH_NEWLINE     = 10'b00_0010_0000,
      PH_NAME        = 10'b00_0100_0000,
      PH_NAME_VALUE  = 10'b00_1000_0000,
      PH_VALUE       = 10'b01_0000_0000,
      PH_END         = 10'b10_0000_0000
   } phase_type;

   phase_type  phase_ff, phase_in, phase_mid;
   cmd_type    cmd;
   logic       ws, lf, cr, colon, accept;

   assign ws     = is_ws(req_tdata);
   assign lf     = (req_tdata == ChLf);
   assign cr     = (req_tdata == ChCr);
   assign colon  = (req_tdata == ChColon);
   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      phase_mid         = phase_ff;
      cmd.op            = OP_NONE;
      cmd.field         = FLD_METHOD;
      cmd.data          = req_tdata;
      cmd.ws            = ws;
      cmd.discard       = 1'b0;
      cmd.discard_field = FLD_METHOD;
      cmd.last          = req_tlast;
      case (phase_ff)
         PH_METHOD, PH_URL: begin
            cmd.field = (phase_ff == PH_METHOD) ? FLD_METHOD : FLD_URL;
            if (!ws) begin
               cmd.op = OP_PLAIN;
            end else begin
               cmd.op    = OP_COMPLETE;
               phase_mid = (phase_ff == PH_METHOD) ? PH_METHOD_URL : PH_URL_VERSION;
            end
         end
         PH_METHOD_URL: begin
            // skip blanks; LF falls through and ends an empty URL
            cmd.field = FLD_URL;
            if (!(ws && !lf)) begin
               if (!ws) begin
                  cmd.op    = OP_PLAIN;
                  phase_mid = PH_URL;
               end else begin
                  cmd.op    = OP_COMPLETE;
                  phase_mid = PH_URL_VERSION;
               end
            end
         end
         PH_URL_VERSION, PH_NAME_VALUE: begin
            cmd.field = (phase_ff == PH_URL_VERSION) ? FLD_VERSION : FLD_VALUE;
            if (!(ws && !lf)) begin
               if (lf) begin
                  cmd.op    = OP_COMPLETE;
                  phase_mid = PH_NEWLINE;
               end else begin
                  cmd.op    = OP_STRIP;
                  phase_mid = (phase_ff == PH_URL_VERSION) ? PH_VERSION : PH_VALUE;
               end
            end
         end
         PH_VERSION, PH_VALUE: begin
            cmd.field = (phase_ff == PH_VERSION) ? FLD_VERSION : FLD_VALUE;
            if (lf) begin
               cmd.op    = OP_COMPLETE;
               phase_mid = PH_NEWLINE;
            end else begin
               cmd.op = OP_STRIP;
            end
         end
         PH_NEWLINE: begin
            cmd.field = FLD_NAME;
            if (cr) begin
               cmd.op = OP_NONE;
            end else if (lf) begin
               phase_mid = PH_END;
            end else if (colon) begin
               cmd.op    = OP_COMPLETE;
               phase_mid = PH_NAME_VALUE;
            end else begin
               cmd.op    = OP_STRIP;
               phase_mid = PH_NAME;
            end
         end
         PH_NAME: begin
            cmd.field = FLD_NAME;
            if (colon) begin
               cmd.op    = OP_COMPLETE;
               phase_mid = PH_NAME_VALUE;
            end else if (lf) begin
               cmd.op    = OP_COMPLETE2;
               phase_mid = PH_NEWLINE;
            end else begin
               cmd.op = OP_STRIP;
            end
         end
         default: begin
            cmd.op = OP_NONE;   // after the header block: ignore body bytes
         end
      endcase

      phase_in = phase_mid;
      if (req_tlast) begin
         // flag the field in progress or expected next
         cmd.discard = 1'b1;
         case (phase_mid)
            PH_METHOD:                      cmd.discard_field = FLD_METHOD;
            PH_METHOD_URL, PH_URL:          cmd.discard_field = FLD_URL;
            PH_URL_VERSION, PH_VERSION:     cmd.discard_field = FLD_VERSION;
            PH_NAME:                        cmd.discard_field = FLD_NAME;
            PH_NAME_VALUE, PH_VALUE:        cmd.discard_field = FLD_VALUE;
            default:                        cmd.discard = 1'b0;
         endcase
         phase_in = PH_METHOD;
      end
   end

   assign push     = accept && ((cmd.op != OP_NONE) || req_tlast);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== rtl/htt_queue.sv =====
// ---------------------------------------------------------------------------
// HTTP header tokenizer command queue
// Short FIFO that decouples the classifier from the emitter.
// ---------------------------------------------------------------------------
module htt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  htt_pkg::cmd_type  push_cmd,
   output logic              full,
   output logic              head_valid,
   output htt_pkg::cmd_type  head_cmd,
   input  logic              pop
);
   import htt_pkg::*;

   cmd_type              slot_ff [CmdDepth];
   logic [CmdPtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CmdCntW-1:0]   cnt_ff;
   logic                 do_push, do_pop;

   assign full       = (cnt_ff == CmdCntW'(CmdDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

// ===== rtl/htt_back.sv =====
// ---------------------------------------------------------------------------
// HTTP header tokenizer emitter
// Carries out queued commands: holds trailing whitespace, releases it, and
// emits content, completion, discard and end items through an output register.
// ---------------------------------------------------------------------------
module htt_back #(
   parameter int PENDING_DEPTH = htt_pkg::PendingDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  htt_pkg::cmd_type  head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] content_byte
   output logic [4:0]        rsp_tuser,   // [1:0] result_kind, [4:2] field_id
   output logic              rsp_tlast    // last_result
);
   import htt_pkg::*;

   localparam int CntW = $clog2(PENDING_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_MAIN    = 4'b0001,
      ST_SECOND  = 4'b0010,
      ST_DISCARD = 4'b0100,
      ST_END     = 4'b1000
   } stage_type;

   stage_type         stage_ff, stage_in, after_main, after_second, after_disc;
   logic [7:0]        pend_ff [PENDING_DEPTH];
   logic [7:0]        pend_in [PENDING_DEPTH];
   logic [CntW-1:0]   cnt_ff, cnt_in, app_idx;
   logic              held_full, last_main, last_second, last_disc;
   logic              emit, emit_last, step_done, done_pops;
   logic              do_shift, do_append, fire, slot_free;
   kind_type          emit_kind;
   field_type         emit_field;
   logic [7:0]        emit_byte;
   logic              out_valid_ff, out_last_ff;
   logic [7:0]        out_data_ff;
   logic [4:0]        out_user_ff;

   assign held_full = (cnt_ff == CntW'(PENDING_DEPTH));
   assign slot_free = !out_valid_ff || rsp_tready;

   // which stages remain after each one
   assign last_disc    = !head_cmd.last;
   assign last_second  = !head_cmd.discard && last_disc;
   assign last_main    = (head_cmd.op != OP_COMPLETE2) && last_second;
   assign after_disc   = ST_END;
   assign after_second = head_cmd.discard ? ST_DISCARD : after_disc;
   assign after_main   = (head_cmd.op == OP_COMPLETE2) ? ST_SECOND : after_second;

   always_comb begin
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_kind  = KIND_CONTENT;
      emit_field = head_cmd.field;
      emit_byte  = 8'h00;
      step_done  = 1'b1;
      done_pops  = 1'b0;
      stage_in   = stage_ff;
      do_shift   = 1'b0;
      do_append  = 1'b0;
      cnt_in     = cnt_ff;
      app_idx    = cnt_ff;
      case (stage_ff)
         ST_MAIN: begin
            stage_in  = after_main;
            done_pops = last_main;
            case (head_cmd.op)
               OP_PLAIN: begin
                  emit      = 1'b1;
                  emit_last = last_main;
                  emit_byte = head_cmd.data;
               end
               OP_STRIP: begin
                  if (head_cmd.ws) begin
                     // hold; on overflow release the oldest held byte
                     do_append = 1'b1;
                     if (held_full) begin
                        emit      = 1'b1;
                        emit_last = last_main;
                        emit_byte = pend_ff[0];
                        do_shift  = 1'b1;
                        app_idx   = CntW'(PENDING_DEPTH - 1);
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end else if (cnt_ff != '0) begin
                     // release held bytes in order before the new byte
                     emit      = 1'b1;
                     emit_byte = pend_ff[0];
                     do_shift  = 1'b1;
                     cnt_in    = cnt_ff - 1'b1;
                     step_done = 1'b0;
                  end else begin
                     emit      = 1'b1;
                     emit_last = last_main;
                     emit_byte = head_cmd.data;
                  end
               end
               OP_COMPLETE, OP_COMPLETE2: begin
                  emit      = 1'b1;
                  emit_last = last_main;
                  emit_kind = KIND_COMPLETE;
                  cnt_in    = '0;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end
         ST_SECOND: begin
            emit       = 1'b1;
            emit_last  = last_second;
            emit_kind  = KIND_COMPLETE;
            emit_field = FLD_VALUE;
            stage_in   = after_second;
            done_pops  = last_second;
         end
         ST_DISCARD: begin
            emit       = 1'b1;
            emit_last  = last_disc;
            emit_kind  = KIND_DISCARD;
            emit_field = head_cmd.discard_field;
            stage_in   = after_disc;
            done_pops  = last_disc;
         end
         default: begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            emit_kind  = KIND_END;
            emit_field = FLD_METHOD;
            cnt_in     = '0;
            done_pops  = 1'b1;
         end
      endcase
      if (!step_done) begin
         stage_in  = stage_ff;
         done_pops = 1'b0;
      end
      if (done_pops) begin
         stage_in = ST_MAIN;
      end
   end

   assign fire = head_valid && (!emit || slot_free);
   assign pop  = fire && done_pops;

   // held-whitespace shift line: entry 0 is the oldest byte
   generate
      for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_pend
         logic [7:0] shifted;
         if (i < PENDING_DEPTH - 1) begin : g_mid
            assign shifted = do_shift ? pend_ff[i+1] : pend_ff[i];
         end else begin : g_top
            assign shifted = pend_ff[i];
         end
         assign pend_in[i] = (do_append && (app_idx == CntW'(i))) ? head_cmd.data : shifted;
         always_ff @(posedge clock) begin
            if (fire) begin
               pend_ff[i] <= pend_in[i];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_MAIN;
         cnt_ff   <= '0;
      end else if (fire) begin
         stage_ff <= stage_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (slot_free) begin
         out_valid_ff <= fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && fire && emit) begin
         out_data_ff <= emit_byte;
         out_user_ff <= {emit_field, emit_kind};
         out_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/http_header_tokenizer.sv =====
// ---------------------------------------------------------------------------
// HTTP header tokenizer
// Byte-serial tokenizer for an HTTP-like start line and header block.
// ---------------------------------------------------------------------------
// Feed one datagram byte per item on the req_ channel with req_tlast on the
// final byte. The block splits the start line into method, URL and version
// and each header line into name and value at the first colon, skipping
// blanks between fields and stripping trailing whitespace from version, names
// and values; an empty line ends the header block and later bytes are
// ignored. Each rsp_ item is a content byte, a field-complete mark, a
// discarded-field mark for a field left open at datagram end, or a datagram
// end mark; rsp_tlast flags the last item caused by one input byte, and a
// byte that causes nothing produces no item. Throughput is one byte per cycle
// while each byte causes at most one item and the output is not stalled, as
// the emitter makes one item per cycle. A non-space byte after held whitespace
// releases it first, LF after a name completes it and an empty value, and
// the final byte adds an end mark after any discard mark. A four-entry queue
// absorbs these bursts; req_tready drops only while it is full. After reset
// the block is ready at once: the whitespace hold line needs no clearing.
// ---------------------------------------------------------------------------
module http_header_tokenizer #(
   parameter int PENDING_DEPTH = htt_pkg::PendingDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] content_byte
   output logic [4:0]  rsp_tuser,    // [1:0] result_kind, [4:2] field_id
   output logic        rsp_tlast     // last_result
);
   import htt_pkg::*;

   logic     push, q_full, head_valid, pop;
   cmd_type  push_cmd, head_cmd;

   // classify each byte and advance the parse phase
   htt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // hold commands so either side can stall on its own
   htt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   // expand each command into result items
   htt_back #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
